FILE: hdl/tlpq_pkg.sv
// Shared types and codes for the three-level priority queue.
`timescale 1ns / 1ps

package tlpq_pkg;

   localparam int OP_BITS      = 2;
   localparam int LEVEL_BITS   = 2;
   localparam int TAG_BITS     = 16;
   localparam int STATUS_BITS  = 2;
   localparam int COUNT_BITS   = 7;
   localparam int LEVEL_NUM    = 3;

   localparam logic [OP_BITS-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_GET   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ACCEL = 2'd2;

   localparam logic [LEVEL_BITS-1:0] LVL_LOW    = 2'd0;
   localparam logic [LEVEL_BITS-1:0] LVL_NORMAL = 2'd1;
   localparam logic [LEVEL_BITS-1:0] LVL_HIGH   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [LEVEL_BITS-1:0] level;
      logic [TAG_BITS-1:0]   payload;
   } req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]    out_payload;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  total_count;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // latch item, issue store reads
      logic commit;    // apply update, write stores, load result
   } cmd_type;

endpackage

FILE: hdl/tlpq_ctrl.sv
// Sequencing controller: item acceptance, execute step and result valid.
`timescale 1ns / 1ps

module tlpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlpq_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   // Hold the execute step while the previous result is still unclaimed.
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/tlpq_datapath.sv
// Queue datapath: entry stores, list pointers, counters and result register.
`timescale 1ns / 1ps

module tlpq_datapath #(
   parameter int DEPTH        = 64,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  tlpq_pkg::cmd_type cmd,
   input  tlpq_pkg::req_type req_data,
   output tlpq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

   // Entry stores
   logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];
   logic [IDX_W-1:0]        link_mem [DEPTH];

   logic [PAYLOAD_BITS-1:0] pay_rd_ff;
   logic [IDX_W-1:0]        link_rd_ff;
   logic [IDX_W-1:0]        rd_addr;

   logic                    pay_wr_en;
   logic [IDX_W-1:0]        pay_wr_addr;
   logic [PAYLOAD_BITS-1:0] pay_wr_data;
   logic                    link_wr_en;
   logic [IDX_W-1:0]        link_wr_addr;
   logic [IDX_W-1:0]        link_wr_data;

   // Item latch
   logic [tlpq_pkg::OP_BITS-1:0]    item_op_ff;
   logic [tlpq_pkg::LEVEL_BITS-1:0] item_lvl_ff;
   logic [tlpq_pkg::TAG_BITS-1:0]   item_tag_ff;

   // List state
   logic [IDX_W-1:0] head_ff  [tlpq_pkg::LEVEL_NUM];
   logic [IDX_W-1:0] head_in  [tlpq_pkg::LEVEL_NUM];
   logic [IDX_W-1:0] tail_ff  [tlpq_pkg::LEVEL_NUM];
   logic [IDX_W-1:0] tail_in  [tlpq_pkg::LEVEL_NUM];
   logic [CNT_W-1:0] count_ff [tlpq_pkg::LEVEL_NUM];
   logic [CNT_W-1:0] count_in [tlpq_pkg::LEVEL_NUM];
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] fresh_count_ff, fresh_count_in;
   logic [CNT_W-1:0] total_ff, total_in;

   tlpq_pkg::rsp_type rsp_ff, rsp_in;

   logic [tlpq_pkg::LEVEL_BITS-1:0] top_lvl;
   logic                            any_held;
   logic                            have_free;
   logic                            have_fresh;
   logic [IDX_W-1:0]                put_slot;
   logic [63:0]                     tag_wide;
   logic [63:0]                     rd_wide;
   logic [31:0]                     total_wide;

   // Highest non-empty level
   always_comb begin
      any_held = 1'b1;
      if (count_ff[tlpq_pkg::LVL_HIGH] != '0) top_lvl = tlpq_pkg::LVL_HIGH;
      else if (count_ff[tlpq_pkg::LVL_NORMAL] != '0) top_lvl = tlpq_pkg::LVL_NORMAL;
      else begin
         top_lvl  = tlpq_pkg::LVL_LOW;
         any_held = (count_ff[tlpq_pkg::LVL_LOW] != '0);
      end
   end

   // A get reads the top head entry, a put reads the free-list link.
   assign rd_addr = (req_data.op == tlpq_pkg::OP_GET) ? head_ff[top_lvl] : free_head_ff;

   assign have_free  = (free_count_ff != '0);
   assign have_fresh = (fresh_count_ff < CNT_DEPTH);
   assign put_slot   = have_free ? free_head_ff : fresh_count_ff[IDX_W-1:0];
   assign tag_wide   = 64'(item_tag_ff);
   assign rd_wide    = 64'(pay_rd_ff);

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      free_head_in   = free_head_ff;
      free_count_in  = free_count_ff;
      fresh_count_in = fresh_count_ff;
      total_in       = total_ff;
      rsp_in         = rsp_ff;
      pay_wr_en      = 1'b0;
      pay_wr_addr    = put_slot;
      pay_wr_data    = tag_wide[PAYLOAD_BITS-1:0];
      link_wr_en     = 1'b0;
      link_wr_addr   = '0;
      link_wr_data   = '0;
      total_wide     = '0;

      if (cmd.commit) begin
         rsp_in.out_payload = '0;
         rsp_in.status      = tlpq_pkg::ST_OK;
         unique case (item_op_ff)
            tlpq_pkg::OP_PUT: begin
               if (!have_free && !have_fresh) begin
                  rsp_in.status = tlpq_pkg::ST_FULL;
               end else begin
                  if (have_free) begin
                     free_head_in  = link_rd_ff;
                     free_count_in = free_count_ff - CNT_ONE;
                  end else begin
                     fresh_count_in = fresh_count_ff + CNT_ONE;
                  end
                  pay_wr_en = 1'b1;
                  if (count_ff[item_lvl_ff] == '0) begin
                     head_in[item_lvl_ff] = put_slot;
                  end else begin
                     link_wr_en   = 1'b1;
                     link_wr_addr = tail_ff[item_lvl_ff];
                     link_wr_data = put_slot;
                  end
                  tail_in[item_lvl_ff]  = put_slot;
                  count_in[item_lvl_ff] = count_ff[item_lvl_ff] + CNT_ONE;
                  total_in              = total_ff + CNT_ONE;
               end
            end
            tlpq_pkg::OP_GET: begin
               if (!any_held) begin
                  rsp_in.status = tlpq_pkg::ST_EMPTY;
               end else begin
                  rsp_in.out_payload = rd_wide[tlpq_pkg::TAG_BITS-1:0];
                  count_in[top_lvl]  = count_ff[top_lvl] - CNT_ONE;
                  if (count_ff[top_lvl] == CNT_ONE) begin
                     head_in[top_lvl] = '0;
                     tail_in[top_lvl] = '0;
                  end else begin
                     head_in[top_lvl] = link_rd_ff;
                  end
                  // Push the freed entry onto the free list.
                  link_wr_en    = 1'b1;
                  link_wr_addr  = head_ff[top_lvl];
                  link_wr_data  = free_head_ff;
                  free_head_in  = head_ff[top_lvl];
                  free_count_in = free_count_ff + CNT_ONE;
                  total_in      = total_ff - CNT_ONE;
               end
            end
            tlpq_pkg::OP_ACCEL: begin
               if (count_ff[tlpq_pkg::LVL_LOW] != '0) begin
                  if (count_ff[tlpq_pkg::LVL_HIGH] == '0) begin
                     head_in[tlpq_pkg::LVL_HIGH] = head_ff[tlpq_pkg::LVL_LOW];
                  end else begin
                     link_wr_en   = 1'b1;
                     link_wr_addr = tail_ff[tlpq_pkg::LVL_HIGH];
                     link_wr_data = head_ff[tlpq_pkg::LVL_LOW];
                  end
                  tail_in[tlpq_pkg::LVL_HIGH]  = tail_ff[tlpq_pkg::LVL_LOW];
                  count_in[tlpq_pkg::LVL_HIGH] = count_ff[tlpq_pkg::LVL_HIGH]
                                               + count_ff[tlpq_pkg::LVL_LOW];
                  count_in[tlpq_pkg::LVL_LOW]  = '0;
                  head_in[tlpq_pkg::LVL_LOW]   = '0;
                  tail_in[tlpq_pkg::LVL_LOW]   = '0;
               end
            end
            default: ;
         endcase
         total_wide         = 32'(total_in);
         rsp_in.total_count = total_wide[tlpq_pkg::COUNT_BITS-1:0];
      end
   end

   // Stores: at most one write (execute) and one registered read (accept) per cycle each
   always_ff @(posedge clock) begin
      if (pay_wr_en) pay_mem[pay_wr_addr] <= pay_wr_data;
      if (cmd.capture) pay_rd_ff <= pay_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_wr_en) link_mem[link_wr_addr] <= link_wr_data;
      if (cmd.capture) link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_op_ff  <= req_data.op;
         // Spare level code goes to the high level.
         item_lvl_ff <= (req_data.level > tlpq_pkg::LVL_HIGH) ? tlpq_pkg::LVL_HIGH
                                                                : req_data.level;
         item_tag_ff <= req_data.payload;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlpq_pkg::LEVEL_NUM; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         free_head_ff   <= '0;
         free_count_ff  <= '0;
         fresh_count_ff <= '0;
         total_ff       <= '0;
      end else begin
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         free_head_ff   <= free_head_in;
         free_count_ff  <= free_count_in;
         fresh_count_ff <= fresh_count_in;
         total_ff       <= total_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/three_level_priority_queue_top.sv
// Top level of the three-level strict-priority queue.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Item
// -------   ---------  ---------------------  ---------------------------------
// req       in         req_valid / req_ready  op, level, payload
// rsp       out        rsp_valid / rsp_ready  out_payload, status, total_count
//
// The accept cycle latches the item and reads the payload and link stores
// into registers. The execute step then writes the payload store for a put and
// at most one link entry, updates the list pointers and loads the result
// register. A pending result stalls only the execute step, so the next item
// is accepted while a result waits. Reset clears pointers and counts at once;
// the stores need no clearing pass since no entry's value is used before it is written.

module three_level_priority_queue_top #(
   parameter int DEPTH        = 64,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlpq_pkg::rsp_type rsp_data
);

   localparam logic [tlpq_pkg::COUNT_BITS-1:0] FULL_TOTAL = tlpq_pkg::COUNT_BITS'(DEPTH);

   tlpq_pkg::cmd_type cmd;

   // Sequence accept, execute and result hand-off.
   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Hold the stores, list pointers and result register.
   tlpq_datapath #(
      .DEPTH        (DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Accept and execute never fall in the same cycle.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit overlap");

   // A new result appears only after an execute step.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("result valid without execute");

   // A get on empty reports no held entries and no tag.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tlpq_pkg::ST_EMPTY) |->
         (rsp_data.total_count == '0 && rsp_data.out_payload == '0))
      else $error("empty get with entries held");

   // A dropped put happens only when every slot is held.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == tlpq_pkg::ST_FULL) |->
         (rsp_data.total_count == FULL_TOTAL))
      else $error("put dropped with free slots");

endmodule
